// ===== src/mqttp_pkg.sv =====
// Package for the MQTT receive packet parser: payload structs, byte role,
// event and packet kind codes. No dependencies.
`default_nettype none

package mqttp_pkg;

   localparam int BYTE_W = 8;
   localparam int LEN_W  = 28;
   localparam int HALF_W = 16;

   // Byte roles
   localparam logic [2:0] ROLE_TYPE    = 3'd0;
   localparam logic [2:0] ROLE_LENGTH  = 3'd1;
   localparam logic [2:0] ROLE_VARHDR  = 3'd2;
   localparam logic [2:0] ROLE_TOPIC   = 3'd3;
   localparam logic [2:0] ROLE_PAYLOAD = 3'd4;
   localparam logic [2:0] ROLE_IGNORED = 3'd5;

   // Events
   localparam logic [3:0] EV_NONE       = 4'd0;
   localparam logic [3:0] EV_CONNECTED  = 4'd1;
   localparam logic [3:0] EV_REFUSED    = 4'd2;
   localparam logic [3:0] EV_MESSAGE    = 4'd3;
   localparam logic [3:0] EV_PUBACK     = 4'd4;
   localparam logic [3:0] EV_SUBACK     = 4'd5;
   localparam logic [3:0] EV_UNSUBACK   = 4'd6;
   localparam logic [3:0] EV_PINGRESP   = 4'd7;
   localparam logic [3:0] EV_UNEXPECTED = 4'd8;
   localparam logic [3:0] EV_MALFORMED  = 4'd9;

   // Control packet kinds (type byte upper nibble)
   localparam logic [3:0] KIND_CONNACK  = 4'd2;
   localparam logic [3:0] KIND_PUBLISH  = 4'd3;
   localparam logic [3:0] KIND_PUBACK   = 4'd4;
   localparam logic [3:0] KIND_SUBACK   = 4'd9;
   localparam logic [3:0] KIND_UNSUBACK = 4'd11;
   localparam logic [3:0] KIND_PINGRESP = 4'd13;

   localparam logic [1:0] QOS_AT_LEAST_ONCE = 2'd1;

   typedef struct packed {
      logic [BYTE_W-1:0] rx_byte;
      logic              start_over;
   } req_type;

   typedef struct packed {
      logic [2:0]        byte_role;
      logic [BYTE_W-1:0] data_byte;
      logic [3:0]        event_res;
      logic [BYTE_W-1:0] return_code;
      logic [1:0]        qos_level;
      logic              retain_flag;
      logic              dup_flag;
      logic [HALF_W-1:0] message_id;
      logic              ack_needed;
      logic [HALF_W-1:0] topic_length;
      logic [LEN_W-1:0]  payload_length;
   } rsp_type;

endpackage

`default_nettype wire

// ===== src/mqttp_req_if.sv =====
// Received-byte channel: valid/ready handshake plus byte payload.
// Depends on mqttp_pkg for widths.
`default_nettype none

interface mqttp_req_if
   import mqttp_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;
   logic              start_over;

   modport source (output valid, output rx_byte, output start_over, input ready);
   modport sink   (input valid, input rx_byte, input start_over, output ready);
endinterface

`default_nettype wire

// ===== src/mqttp_rsp_if.sv =====
// Result channel: valid/ready handshake plus per-byte role and event fields.
// Depends on mqttp_pkg for widths.
`default_nettype none

interface mqttp_rsp_if
   import mqttp_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [2:0]        byte_role;
   logic [BYTE_W-1:0] data_byte;
   logic [3:0]        event_res;
   logic [BYTE_W-1:0] return_code;
   logic [1:0]        qos_level;
   logic              retain_flag;
   logic              dup_flag;
   logic [HALF_W-1:0] message_id;
   logic              ack_needed;
   logic [HALF_W-1:0] topic_length;
   logic [LEN_W-1:0]  payload_length;

   modport source (output valid, output byte_role, output data_byte, output event_res,
                   output return_code, output qos_level, output retain_flag,
                   output dup_flag, output message_id, output ack_needed,
                   output topic_length, output payload_length, input ready);
   modport sink   (input valid, input byte_role, input data_byte, input event_res,
                   input return_code, input qos_level, input retain_flag,
                   input dup_flag, input message_id, input ack_needed,
                   input topic_length, input payload_length, output ready);
endinterface

`default_nettype wire

// ===== src/mqttp_frame.sv =====
// Frame tracker: holds the packet state and computes one byte's result.
// Depends on mqttp_pkg.
`default_nettype none

module mqttp_frame
   import mqttp_pkg::*;
#(
   parameter int MAX_LENGTH_BYTES = 4
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    step_en,
   input  wire req_type req,
   output rsp_type      rsp
);

   typedef enum logic [1:0] {PH_TYPE, PH_LEN, PH_BODY} phase_type;

   localparam logic [2:0] MAX_LB = 3'(MAX_LENGTH_BYTES);

   phase_type         phase_ff, phase_in;
   logic [BYTE_W-1:0] type_ff, type_in;
   logic [LEN_W-1:0]  rem_ff, rem_in;
   logic [1:0]        cnt_ff, cnt_in;
   logic [LEN_W-1:0]  pos_ff, pos_in;
   logic [HALF_W-1:0] topic_ff, topic_in;
   logic [HALF_W-1:0] msgid_ff, msgid_in;
   logic [BYTE_W-1:0] code_ff, code_in;

   logic              finish;
   logic              malformed;
   logic [2:0]        role;
   logic [LEN_W-1:0]  group_val;
   logic [LEN_W:0]    pos_next;
   logic [16:0]       tend;
   logic [3:0]        kind;
   logic [1:0]        qos;
   logic [LEN_W-1:0]  tend_w;

   // finish-side values
   logic [17:0]       pub_pos;
   logic [17:0]       pub_pos_id;
   logic [17:0]       pay_pos;
   logic              pub_ok;

   assign kind     = type_ff[7:4];
   assign qos      = type_ff[2:1];
   assign tend     = 17'(topic_ff) + 17'd2;
   assign tend_w   = LEN_W'(tend);
   assign pos_next = {1'b0, pos_ff} + (LEN_W+1)'(1);

   // 7-bit group placed by its index, least significant first
   always_comb begin
      case (cnt_ff)
         2'd0:    group_val = LEN_W'(req.rx_byte[6:0]);
         2'd1:    group_val = LEN_W'({req.rx_byte[6:0], 7'b0});
         2'd2:    group_val = LEN_W'({req.rx_byte[6:0], 14'b0});
         default: group_val = {req.rx_byte[6:0], 21'b0};
      endcase
   end

   always_comb begin
      phase_in  = phase_ff;
      type_in   = type_ff;
      rem_in    = rem_ff;
      cnt_in    = cnt_ff;
      pos_in    = pos_ff;
      topic_in  = topic_ff;
      msgid_in  = msgid_ff;
      code_in   = code_ff;
      finish    = 1'b0;
      malformed = 1'b0;
      role      = ROLE_TYPE;
      if (req.start_over || phase_ff == PH_TYPE) begin
         type_in  = req.rx_byte;
         rem_in   = '0;
         cnt_in   = '0;
         pos_in   = '0;
         topic_in = '0;
         msgid_in = '0;
         code_in  = '0;
         phase_in = PH_LEN;
      end else if (phase_ff == PH_LEN) begin
         role   = ROLE_LENGTH;
         rem_in = rem_ff + group_val;
         if (req.rx_byte[7]) begin
            if ((3'(cnt_ff) + 3'd1) >= MAX_LB) begin
               malformed = 1'b1;
               phase_in  = PH_TYPE;
            end else begin
               cnt_in = cnt_ff + 2'd1;
            end
         end else if (rem_in == '0) begin
            finish = 1'b1;
         end else begin
            phase_in = PH_BODY;
            pos_in   = '0;
         end
      end else begin
         case (kind)
            KIND_CONNACK: begin
               role = (pos_ff < LEN_W'(2)) ? ROLE_VARHDR : ROLE_IGNORED;
               if (pos_ff == LEN_W'(1)) code_in = req.rx_byte;
            end
            KIND_PUBLISH: begin
               if (pos_ff == '0) begin
                  topic_in = {req.rx_byte, 8'h00};
                  role     = ROLE_VARHDR;
               end else if (pos_ff == LEN_W'(1)) begin
                  topic_in = {topic_ff[15:8], req.rx_byte};
                  role     = ROLE_VARHDR;
               end else if (pos_ff < tend_w) begin
                  role = ROLE_TOPIC;
               end else if (qos != 2'd0 && pos_ff == tend_w) begin
                  msgid_in = {req.rx_byte, 8'h00};
                  role     = ROLE_VARHDR;
               end else if (qos != 2'd0 && pos_ff == tend_w + LEN_W'(1)) begin
                  msgid_in = {msgid_ff[15:8], req.rx_byte};
                  role     = ROLE_VARHDR;
               end else begin
                  role = ROLE_PAYLOAD;
               end
            end
            default: role = ROLE_IGNORED;
         endcase
         pos_in = pos_next[LEN_W-1:0];
         if (pos_next >= {1'b0, rem_ff}) finish = 1'b1;
      end
      if (finish) phase_in = PH_TYPE;
   end

   // end-of-packet event, taken from the updated state
   assign pub_pos    = 18'(topic_in) + 18'd2;
   assign pub_pos_id = pub_pos + 18'd2;
   assign pay_pos    = (qos != 2'd0) ? pub_pos_id : pub_pos;
   assign pub_ok     = (rem_in >= LEN_W'(2)) && (LEN_W'(pub_pos) <= rem_in)
                       && ((qos == 2'd0) || (LEN_W'(pub_pos_id) <= rem_in));

   always_comb begin
      rsp           = '0;
      rsp.byte_role = role;
      rsp.data_byte = req.rx_byte;
      if (malformed) begin
         rsp.event_res = EV_MALFORMED;
      end else if (finish) begin
         case (kind)
            KIND_CONNACK: begin
               if (rem_in >= LEN_W'(2)) begin
                  if (code_in == '0) begin
                     rsp.event_res = EV_CONNECTED;
                  end else begin
                     rsp.event_res   = EV_REFUSED;
                     rsp.return_code = code_in;
                  end
               end
            end
            KIND_PUBLISH: begin
               if (pub_ok) begin
                  rsp.event_res      = EV_MESSAGE;
                  rsp.qos_level      = qos;
                  rsp.retain_flag    = type_ff[0];
                  rsp.dup_flag       = type_ff[3];
                  rsp.message_id     = (qos != 2'd0) ? msgid_in : '0;
                  rsp.ack_needed     = (qos == QOS_AT_LEAST_ONCE) && (msgid_in != '0);
                  rsp.topic_length   = topic_in;
                  rsp.payload_length = rem_in - LEN_W'(pay_pos);
               end
            end
            KIND_PUBACK:   rsp.event_res = EV_PUBACK;
            KIND_SUBACK:   rsp.event_res = EV_SUBACK;
            KIND_UNSUBACK: rsp.event_res = EV_UNSUBACK;
            KIND_PINGRESP: rsp.event_res = EV_PINGRESP;
            default:       rsp.event_res = EV_UNEXPECTED;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_TYPE;
      end else if (step_en) begin
         phase_ff <= phase_in;
      end
      if (step_en) begin
         type_ff  <= type_in;
         rem_ff   <= rem_in;
         cnt_ff   <= cnt_in;
         pos_ff   <= pos_in;
         topic_ff <= topic_in;
         msgid_ff <= msgid_in;
         code_ff  <= code_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/mqtt_receive_packet_parser.sv =====
// MQTT 3.1.1 receive packet parser, top level: input register, frame
// tracker and result register. Depends on mqttp_pkg, mqttp_req_if,
// mqttp_rsp_if and mqttp_frame.
//
// Usage:
//  - req_bus carries one received byte per item (rx_byte) and start_over,
//    which forces that byte to be taken as a packet type byte.
//  - rsp_bus returns one item per byte: its role in the packet, the byte
//    itself, and on the last byte of a packet the event with its fields.
//  - Path: an item accepted into the input register is parsed against the
//    frame state and written into the result register, which offers it on
//    rsp_bus.
//  - Throughput: one byte per cycle when not stalled; the frame state update
//    is a single short combinational step between the two registers.
//  - Stall: when the receiver holds rsp ready low, the result register
//    keeps its item and the input register, if empty, takes one more byte;
//    after that req ready drops until the result is taken.
//  - Reset: both registers empty, the parser waits for a type byte.
`default_nettype none

module mqtt_receive_packet_parser
   import mqttp_pkg::*;
#(
   parameter int MAX_LENGTH_BYTES = 4
) (
   input  wire logic   clock,
   input  wire logic   reset,
   mqttp_req_if.sink   req_bus,
   mqttp_rsp_if.source rsp_bus
);

   // input stage
   logic    in_valid_ff;
   req_type in_ff;
   // result stage
   logic    out_valid_ff;
   rsp_type out_ff;

   logic    step_en;
   rsp_type frame_rsp;
   req_type req_in;

   // byte moves into the result register when that register is free or drains
   assign step_en       = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || step_en;

   assign req_in.rx_byte    = req_bus.rx_byte;
   assign req_in.start_over = req_bus.start_over;

   mqttp_frame #(
      .MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)
   ) u_frame (
      .clock  (clock),
      .reset  (reset),
      .step_en(step_en),
      .req    (in_ff),
      .rsp    (frame_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_bus.ready) in_valid_ff <= req_bus.valid;
         if (!out_valid_ff || rsp_bus.ready) out_valid_ff <= in_valid_ff;
      end
      if (req_bus.valid && req_bus.ready) in_ff <= req_in;
      if (step_en) out_ff <= frame_rsp;
   end

   assign rsp_bus.valid          = out_valid_ff;
   assign rsp_bus.byte_role      = out_ff.byte_role;
   assign rsp_bus.data_byte      = out_ff.data_byte;
   assign rsp_bus.event_res      = out_ff.event_res;
   assign rsp_bus.return_code    = out_ff.return_code;
   assign rsp_bus.qos_level      = out_ff.qos_level;
   assign rsp_bus.retain_flag    = out_ff.retain_flag;
   assign rsp_bus.dup_flag       = out_ff.dup_flag;
   assign rsp_bus.message_id     = out_ff.message_id;
   assign rsp_bus.ack_needed     = out_ff.ack_needed;
   assign rsp_bus.topic_length   = out_ff.topic_length;
   assign rsp_bus.payload_length = out_ff.payload_length;

   // both stages come out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !out_valid_ff && !in_valid_ff)
      else $error("stages not empty after reset");

   // a buffered byte is never lost while waiting for the result stage
   a_in_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !step_en |=> in_valid_ff && $stable(in_ff))
      else $error("input stage dropped a byte");

   // a forced restart byte is always reported as a type byte
   a_restart_role: assert property (@(posedge clock) disable iff (reset)
      step_en && in_ff.start_over |=> out_valid_ff && out_ff.byte_role == ROLE_TYPE)
      else $error("restart byte not tagged as type");

   // ack request only comes with a QoS 1 message event
   a_ack_qos1: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.ack_needed |->
         out_ff.event_res == EV_MESSAGE && out_ff.qos_level == QOS_AT_LEAST_ONCE)
      else $error("ack flag without QoS 1 message");

endmodule

`default_nettype wire

// ===== verif/tb_mqtt_receive_packet_parser.sv =====
`timescale 1ns / 100ps
// Testbench for mqtt_receive_packet_parser: streams MQTT control packets byte by byte
// and checks every result item against a local frame parser. Depends on mqttp_pkg,
// mqttp_req_if, mqttp_rsp_if and the parser RTL.

module tb_mqtt_receive_packet_parser;
   import mqttp_pkg::*;

   localparam int MAX_LEN_GROUPS = 4;
   localparam int RANDOM_BYTES   = 380;
   localparam int QUIET_TAIL     = 120;   // last random bytes go without idling
   localparam int DRAIN_CYCLES   = 8;     // two register stages, plus margin

   typedef logic [7:0] byte_q_type[$];
   typedef enum logic [1:0] {FR_TYPE, FR_LENGTH, FR_BODY} frame_phase_type;

   logic clock;
   logic reset;

   mqttp_req_if req_if ();
   mqttp_rsp_if rsp_if ();

   mqtt_receive_packet_parser #(.MAX_LENGTH_BYTES(MAX_LEN_GROUPS)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if)
   );

   // Frame tracker mirror: what the parser should hold between bytes.
   frame_phase_type fr_phase;
   logic [7:0]   fr_type;
   logic [27:0]  fr_rem_len;
   logic [1:0]   fr_groups;
   logic [27:0]  fr_pos;
   logic [15:0]  fr_topic_len;
   logic [15:0]  fr_msg_id;
   logic [7:0]   fr_connack_rc;

   rsp_type expected_rsp_q[$];
   byte_q_type no_body;

   int  error_count;
   int  bytes_sent;
   int  packets_sent;
   int  events_checked;
   bit  idle_on;
   int  stall_left;

   always #5 clock = ~clock;

   // Last byte of a packet: decide the event from the kind and the collected fields.
   function automatic rsp_type close_packet(rsp_type r);
      logic [3:0]  kind;
      logic [1:0]  qos;
      int unsigned len;
      int unsigned pos;
      kind = fr_type[7:4];
      qos  = fr_type[2:1];
      len  = fr_rem_len;
      pos  = 2 + fr_topic_len;
      fr_phase = FR_TYPE;
      case (kind)
         KIND_CONNACK: begin
            // short CONNACK is dropped without an event
            if (len >= 2) begin
               if (fr_connack_rc == 8'h00) begin
                  r.event_res = EV_CONNECTED;
               end else begin
                  r.event_res   = EV_REFUSED;
                  r.return_code = fr_connack_rc;
               end
            end
         end
         KIND_PUBLISH: begin
            // identifier takes two bytes after the topic for any nonzero qos
            if (qos != 2'd0) pos += 2;
            if (len >= 2 && pos <= len) begin
               r.event_res      = EV_MESSAGE;
               r.qos_level      = qos;
               r.retain_flag    = fr_type[0];
               r.dup_flag       = fr_type[3];
               r.message_id     = (qos != 2'd0) ? fr_msg_id : 16'h0000;
               r.ack_needed     = (qos == QOS_AT_LEAST_ONCE) && (fr_msg_id != 16'h0000);
               r.topic_length   = fr_topic_len;
               r.payload_length = 28'(len - pos);
            end
         end
         KIND_PUBACK:   r.event_res = EV_PUBACK;
         KIND_SUBACK:   r.event_res = EV_SUBACK;
         KIND_UNSUBACK: r.event_res = EV_UNSUBACK;
         KIND_PINGRESP: r.event_res = EV_PINGRESP;
         default:       r.event_res = EV_UNEXPECTED;
      endcase
      return r;
   endfunction

   // Advance the mirror by one received byte and return the result it must cause.
   function automatic rsp_type parse_byte(logic [7:0] b, logic so);
      rsp_type     r;
      logic [3:0]  kind;
      logic [1:0]  qos;
      int unsigned p;
      int unsigned topic_end;
      r = '0;
      r.data_byte = b;
      if (so || fr_phase == FR_TYPE) begin
         fr_type       = b;
         fr_rem_len    = '0;
         fr_groups     = '0;
         fr_pos        = '0;
         fr_topic_len  = '0;
         fr_msg_id     = '0;
         fr_connack_rc = '0;
         fr_phase      = FR_LENGTH;
         r.byte_role   = ROLE_TYPE;
         return r;
      end
      if (fr_phase == FR_LENGTH) begin
         r.byte_role = ROLE_LENGTH;
         fr_rem_len  = fr_rem_len + (28'(b[6:0]) << (7 * fr_groups));
         if (b[7]) begin
            if (int'(fr_groups) + 1 >= MAX_LEN_GROUPS) begin
               r.event_res = EV_MALFORMED;
               fr_phase    = FR_TYPE;
            end else begin
               fr_groups = fr_groups + 2'd1;
            end
         end else if (fr_rem_len == '0) begin
            r = close_packet(r);
         end else begin
            fr_phase = FR_BODY;
            fr_pos   = '0;
         end
         return r;
      end
      kind      = fr_type[7:4];
      qos       = fr_type[2:1];
      p         = fr_pos;
      topic_end = 2 + fr_topic_len;
      if (kind == KIND_CONNACK) begin
         r.byte_role = (p < 2) ? ROLE_VARHDR : ROLE_IGNORED;
         if (p == 1) fr_connack_rc = b;
      end else if (kind == KIND_PUBLISH) begin
         if (p == 0) begin
            fr_topic_len = {b, 8'h00};
            r.byte_role  = ROLE_VARHDR;
         end else if (p == 1) begin
            fr_topic_len = fr_topic_len | 16'(b);
            r.byte_role  = ROLE_VARHDR;
         end else if (p < topic_end) begin
            r.byte_role = ROLE_TOPIC;
         end else if (qos != 2'd0 && p == topic_end) begin
            fr_msg_id   = {b, 8'h00};
            r.byte_role = ROLE_VARHDR;
         end else if (qos != 2'd0 && p == topic_end + 1) begin
            fr_msg_id   = fr_msg_id | 16'(b);
            r.byte_role = ROLE_VARHDR;
         end else begin
            r.byte_role = ROLE_PAYLOAD;
         end
      end else begin
         r.byte_role = ROLE_IGNORED;
      end
      fr_pos = 28'(p + 1);
      if (p + 1 >= fr_rem_len) r = close_packet(r);
      return r;
   endfunction

   // PUBLISH body: topic length field, topic bytes, optional identifier, payload.
   function automatic byte_q_type make_publish(logic [15:0] tlen_field, int topic_bytes,
                                               bit with_id, logic [15:0] id,
                                               int payload_bytes);
      byte_q_type q;
      q.push_back(tlen_field[15:8]);
      q.push_back(tlen_field[7:0]);
      repeat (topic_bytes) q.push_back(8'($urandom));
      if (with_id) begin
         q.push_back(id[15:8]);
         q.push_back(id[7:0]);
      end
      repeat (payload_bytes) q.push_back(8'($urandom));
      return q;
   endfunction

   // One item on the byte channel; called at a rising edge, returns at its acceptance.
   task automatic send_byte(input logic [7:0] b, input logic so);
      if (idle_on && $urandom_range(0, 7) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.rx_byte    <= b;
      req_if.start_over <= so;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      expected_rsp_q.push_back(parse_byte(b, so));
      bytes_sent++;
   endtask

   // Type byte and remaining length; pad adds non-minimal zero groups.
   task automatic send_header(input logic [7:0] hdr_byte, input logic so,
                              input int unsigned len, input int pad);
      byte_q_type grp;
      do begin
         grp.push_back({1'b0, 7'(len)});
         len >>= 7;
      end while (len != 0);
      while (pad > 0 && grp.size() < MAX_LEN_GROUPS) begin
         grp.push_back(8'h00);
         pad--;
      end
      foreach (grp[i]) if (i < grp.size() - 1) grp[i][7] = 1'b1;
      send_byte(hdr_byte, so);
      foreach (grp[i]) send_byte(grp[i], 1'b0);
   endtask

   task automatic send_packet(input logic [7:0] hdr_byte, input logic so,
                              input byte_q_type body, input int pad);
      send_header(hdr_byte, so, body.size(), pad);
      foreach (body[i]) send_byte(body[i], 1'b0);
      packets_sent++;
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         error_count++;
      end
   endtask

   task automatic check_result();
      rsp_type want;
      if (expected_rsp_q.size() == 0) begin
         $display("%0t: result item with nothing pending, expected none, actual byte %02h",
                  $time, rsp_if.data_byte);
         error_count++;
         return;
      end
      want = expected_rsp_q.pop_front();
      if (want.event_res != EV_NONE) events_checked++;
      compare_field("byte_role",      want.byte_role,      rsp_if.byte_role);
      compare_field("data_byte",      want.data_byte,      rsp_if.data_byte);
      compare_field("event_res",      want.event_res,      rsp_if.event_res);
      compare_field("return_code",    want.return_code,    rsp_if.return_code);
      compare_field("qos_level",      want.qos_level,      rsp_if.qos_level);
      compare_field("retain_flag",    want.retain_flag,    rsp_if.retain_flag);
      compare_field("dup_flag",       want.dup_flag,       rsp_if.dup_flag);
      compare_field("message_id",     want.message_id,     rsp_if.message_id);
      compare_field("ack_needed",     want.ack_needed,     rsp_if.ack_needed);
      compare_field("topic_length",   want.topic_length,   rsp_if.topic_length);
      compare_field("payload_length", want.payload_length, rsp_if.payload_length);
   endtask

   // Result side: check accepted items, then pick ready for the next edge.
   always @(posedge clock) begin
      logic next_ready;
      if (reset) begin
         next_ready = 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) check_result();
         if (idle_on && stall_left > 0) begin
            stall_left--;
            next_ready = 1'b0;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 12) - 1;
            next_ready = 1'b0;
         end else begin
            next_ready = 1'b1;
         end
      end
      rsp_if.ready <= next_ready;
   end

   task automatic test_connack();
      send_packet({KIND_CONNACK, 4'h0}, 1'b0, '{8'h00, 8'h00}, 0);                 // accepted
      send_packet({KIND_CONNACK, 4'h0}, 1'b0, '{8'h01, 8'h05}, 0);                 // refused
      send_packet({KIND_CONNACK, 4'h0}, 1'b0, '{8'h00, 8'hFF, 8'hAA, 8'h55}, 1);   // extra body
      send_packet({KIND_CONNACK, 4'h0}, 1'b0, '{8'h00}, 0);                        // short
      send_packet({KIND_CONNACK, 4'h0}, 1'b0, no_body, 0);                         // empty
      send_packet({KIND_CONNACK, 4'hF}, 1'b0, '{8'h00, 8'h80}, 3);                 // padded length
   endtask

   task automatic test_publish();
      send_packet({KIND_PUBLISH, 1'b0, 2'd0, 1'b0}, 1'b0, make_publish(3, 3, 0, 0, 4), 0);
      send_packet({KIND_PUBLISH, 1'b1, QOS_AT_LEAST_ONCE, 1'b1}, 1'b0,
                  make_publish(2, 2, 1, 16'h1234, 3), 0);
      // qos 1 with identifier zero: no ack wanted
      send_packet({KIND_PUBLISH, 1'b0, QOS_AT_LEAST_ONCE, 1'b0}, 1'b0,
                  make_publish(1, 1, 1, 16'h0000, 2), 0);
      send_packet({KIND_PUBLISH, 1'b0, 2'd2, 1'b1}, 1'b0, make_publish(4, 4, 1, 16'hFFFF, 0), 0);
      send_packet({KIND_PUBLISH, 1'b1, 2'd3, 1'b0}, 1'b0, make_publish(0, 0, 1, 16'h0001, 5), 0);
      send_packet({KIND_PUBLISH, 4'h0}, 1'b0, make_publish(0, 0, 0, 0, 0), 0);  // bare topic field
      send_packet({KIND_PUBLISH, 4'h0}, 1'b0, '{8'h00}, 0);                      // short
      send_packet({KIND_PUBLISH, 4'h0}, 1'b0, make_publish(16'h0105, 2, 0, 0, 0), 0); // topic too long
      // qos 1 with no room, then half room, for the identifier
      send_packet({KIND_PUBLISH, 1'b0, QOS_AT_LEAST_ONCE, 1'b0}, 1'b0, make_publish(2, 2, 0, 0, 0), 0);
      send_packet({KIND_PUBLISH, 1'b0, QOS_AT_LEAST_ONCE, 1'b0}, 1'b0, make_publish(2, 2, 0, 0, 1), 0);
      // two-group remaining length
      send_packet({KIND_PUBLISH, 4'h1}, 1'b0, make_publish(1, 1, 0, 0, 130), 0);
   endtask

   task automatic test_other_types();
      byte_q_type body;
      for (int k = 0; k < 16; k++) begin
         if (4'(k) != KIND_CONNACK && 4'(k) != KIND_PUBLISH) begin
            body.delete();
            repeat (k % 3) body.push_back(8'($urandom));
            send_packet({4'(k), 4'(k)}, 1'b0, body, 0);
         end
      end
   endtask

   task automatic test_length_encoding();
      // fifth group never comes: the fourth continuation byte is malformed
      send_byte({KIND_PUBLISH, 4'h0}, 1'b0);
      repeat (MAX_LEN_GROUPS) send_byte(8'hFF, 1'b0);
      send_packet({KIND_PINGRESP, 4'h0}, 1'b0, no_body, 0);   // resync without start_over
      // largest length, then abandoned
      send_byte({KIND_PUBLISH, 4'h0}, 1'b0);
      repeat (MAX_LEN_GROUPS - 1) send_byte(8'hFF, 1'b0);
      send_byte(8'h7F, 1'b0);
      repeat (3) send_byte(8'($urandom), 1'b0);
      send_packet({KIND_PUBACK, 4'h0}, 1'b1, '{8'h00, 8'h07}, 2);
   endtask

   task automatic test_start_over();
      send_header({KIND_PUBLISH, 4'h2}, 1'b0, 10, 0);
      repeat (3) send_byte(8'($urandom), 1'b0);
      send_packet({KIND_CONNACK, 4'h0}, 1'b1, '{8'h00, 8'h00}, 0);   // mid body
      send_byte({KIND_SUBACK, 4'h0}, 1'b0);
      send_byte(8'h85, 1'b0);
      send_packet({KIND_PINGRESP, 4'h0}, 1'b1, no_body, 0);         // mid length
      send_packet({KIND_UNSUBACK, 4'h0}, 1'b1, '{8'h00, 8'h02}, 0);  // while idle
   endtask

   // Mostly well-formed packets with random content; the rest truncated or noise.
   task automatic test_random_stream();
      int         stop_at;
      int         pick;
      int         pad;
      int         claimed;
      bit         resync;
      logic       so;
      logic [3:0] flags;
      logic [15:0] tlen;
      int         tbytes;
      bit         with_id;
      byte_q_type body;
      stop_at = bytes_sent + RANDOM_BYTES;
      resync  = 1'b0;
      while (bytes_sent < stop_at) begin
         idle_on = (stop_at - bytes_sent > QUIET_TAIL);
         pick = $urandom_range(0, 99);
         pad  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
         so   = resync || ($urandom_range(0, 9) == 0);
         resync = 1'b0;
         body.delete();
         if (pick < 45) begin
            flags = 4'($urandom);
            if ($urandom_range(0, 9) == 0) begin
               tlen   = 16'($urandom);
               tbytes = $urandom_range(0, 6);
            end else begin
               tlen   = $urandom_range(0, 8);
               tbytes = tlen;
            end
            with_id = (flags[2:1] != 2'd0) && ($urandom_range(0, 9) != 0);
            body = make_publish(tlen, tbytes, with_id,
                                ($urandom_range(0, 7) == 0) ? 16'h0000 : 16'($urandom),
                                $urandom_range(0, 10));
            send_packet({KIND_PUBLISH, flags}, so, body, pad);
         end else if (pick < 60) begin
            if ($urandom_range(0, 9) != 0) begin
               body.push_back(8'($urandom));
               body.push_back(($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom));
               repeat ($urandom_range(0, 2)) body.push_back(8'($urandom));
            end else begin
               repeat ($urandom_range(0, 1)) body.push_back(8'($urandom));
            end
            send_packet({KIND_CONNACK, 4'($urandom)}, so, body, pad);
         end else if (pick < 80) begin
            repeat ($urandom_range(0, 4)) body.push_back(8'($urandom));
            send_packet(8'($urandom), so, body, pad);
         end else if (pick < 90) begin
            claimed = $urandom_range(3, 20);
            send_header(($urandom_range(0, 1) == 0) ? {KIND_PUBLISH, 4'($urandom)}
                                                    : 8'($urandom), so, claimed, pad);
            repeat ($urandom_range(0, claimed - 1)) send_byte(8'($urandom), 1'b0);
            resync = 1'b1;
         end else begin
            repeat ($urandom_range(1, 5)) send_byte(8'($urandom), 1'($urandom));
            resync = 1'b1;
         end
      end
      idle_on = 1'b0;
   endtask

   initial begin
      clock             = 1'b0;
      reset             = 1'b1;
      req_if.valid      = 1'b0;
      req_if.rx_byte    = 8'h00;
      req_if.start_over = 1'b0;
      rsp_if.ready      = 1'b0;
      fr_phase          = FR_TYPE;
      fr_type           = '0;
      fr_rem_len        = '0;
      fr_groups         = '0;
      fr_pos            = '0;
      fr_topic_len      = '0;
      fr_msg_id         = '0;
      fr_connack_rc     = '0;
      error_count       = 0;
      bytes_sent        = 0;
      packets_sent      = 0;
      events_checked    = 0;
      stall_left        = 0;
      idle_on           = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_connack();
      test_publish();
      test_other_types();
      test_length_encoding();
      test_start_over();
      test_random_stream();
      req_if.valid <= 1'b0;

      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d bytes in %0d whole packets plus truncated frames and noise;",
               bytes_sent, packets_sent);
      $display("checked every result item, %0d of them carrying an event.", events_checked);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Hang guard, far beyond the slowest legal run.
   initial begin
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule

// ===== files.f =====
src/mqttp_pkg.sv
src/mqttp_req_if.sv
src/mqttp_rsp_if.sv
src/mqttp_frame.sv
src/mqtt_receive_packet_parser.sv
verif/tb_mqtt_receive_packet_parser.sv
